[hdl/ilst_pkg.sv]
`default_nettype none
package ilst_pkg;

  // Widest cell index: CAPACITY can reach 256, so a count needs 9 bits
  localparam int MAX_IDX_W = 9;
  typedef logic [MAX_IDX_W-1:0] idx_t;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_INSERT     = 4'd4,
    CMD_REMOVE     = 4'd5,
    CMD_GET        = 4'd6,
    CMD_FIND       = 4'd7,
    CMD_CLEAR      = 4'd8
  } cmd_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_WRITE  = 3'd2,
    OP_DELETE = 3'd3,
    OP_FIND   = 3'd4,
    OP_GET    = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    idx_t     at;
    idx_t     occ;
  } cell_ctl_t;

  typedef struct packed {
    logic [3:0]         command;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [3:0]         found_position;
    logic [4:0]         entry_count;
    logic               is_empty;
  } out_rsp_t;

endpackage
`default_nettype wire

[hdl/ilst_chan_if.sv]
`default_nettype none
interface ilst_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/ilst_cell.sv]
`default_nettype none
module ilst_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ilst_pkg::cell_ctl_t   ctl,
  input  wire logic [DATA_WIDTH-1:0] new_val,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  output logic      [DATA_WIDTH-1:0] data,
  output logic                       hit
);

  localparam ilst_pkg::idx_t MY_IDX = ilst_pkg::idx_t'(INDEX);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  hit_r, hit_nxt;

  always_comb begin
    data_nxt = data_r;
    hit_nxt  = 1'b0;
    unique case (ctl.op)
      ilst_pkg::OP_INSERT: begin
        if (MY_IDX > ctl.at) begin
          data_nxt = left_data;
        end else if (MY_IDX == ctl.at) begin
          data_nxt = new_val;
        end
      end
      ilst_pkg::OP_WRITE: begin
        if (MY_IDX == ctl.at) begin
          data_nxt = new_val;
        end
      end
      ilst_pkg::OP_DELETE: begin
        if (MY_IDX >= ctl.at) begin
          data_nxt = right_data;
        end
      end
      ilst_pkg::OP_FIND: hit_nxt = (MY_IDX < ctl.occ) && (data_r == new_val);
      ilst_pkg::OP_GET:  hit_nxt = (MY_IDX == ctl.at);
      default: ;
    endcase
  end

  // hit flag holds while the cell op is OP_HOLD, so a stalled result stage still sees it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.op != ilst_pkg::OP_HOLD) begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule
`default_nettype wire

[hdl/indexed_list_engine_unit.sv]
// Requests: a new request is taken only once the result stage has loaded the
// last one; the cell row updates on the accept edge and the result stage
// reduces the cell match flags into the output register once that register is free.
// The output register lets a new request in while a result waits.
// Reset: occupancy cleared, both channels empty; entry storage is not cleared.
`default_nettype none
module indexed_list_engine_unit #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ilst_chan_if.sink   in_chan,
  ilst_chan_if.source out_chan
);

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > 5) ? OCC_W : 5;

  logic                      busy_r, busy_nxt;
  logic [OCC_W-1:0]          occ_r, occ_nxt;
  logic [2:0]                st_r, st_nxt;
  logic                      find_r, find_nxt;
  logic                      get_r, get_nxt;
  logic                      out_valid_r, out_valid_nxt;
  ilst_pkg::out_rsp_t        out_data_r, out_data_nxt;

  logic                      accept;
  logic                      load;
  ilst_pkg::cmd_t            cmd;
  logic [CMP_W-1:0]          pos_c, occ_c;
  logic [63:0]               val_wide;
  logic [DATA_WIDTH-1:0]     new_val;
  ilst_pkg::cell_ctl_t       ctl;
  logic [DATA_WIDTH-1:0]     cell_data [CAPACITY];
  logic [CAPACITY-1:0]       hit;
  logic [CAPACITY-1:0]       first_hit;
  logic [OCC_W-1:0]          hit_idx;
  logic [DATA_WIDTH-1:0]     hit_data;
  logic [63:0]               rd_wide;

  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !busy_r;
  assign load = busy_r && (!out_valid_r || out_chan.ready);

  assign cmd      = ilst_pkg::cmd_t'(in_chan.data.command);
  assign pos_c    = CMP_W'(in_chan.data.position);
  assign occ_c    = CMP_W'(occ_r);
  assign val_wide = {32'b0, in_chan.data.item_value};
  assign new_val  = val_wide[DATA_WIDTH-1:0];

  // Request decode: status, new occupancy and the broadcast to the cell row
  always_comb begin
    occ_nxt  = occ_r;
    st_nxt   = st_r;
    find_nxt = find_r;
    get_nxt  = get_r;
    ctl.op   = ilst_pkg::OP_HOLD;
    ctl.at   = '0;
    ctl.occ  = ilst_pkg::idx_t'(occ_r);
    if (accept) begin
      st_nxt   = ilst_pkg::ST_OK;
      find_nxt = 1'b0;
      get_nxt  = 1'b0;
      unique case (cmd)
        ilst_pkg::CMD_PUSH_FRONT,
        ilst_pkg::CMD_PUSH_BACK: begin
          if (occ_r == OCC_W'(CAPACITY)) begin
            st_nxt = ilst_pkg::ST_FULL;
          end else begin
            occ_nxt = occ_r + OCC_W'(1);
            if (cmd == ilst_pkg::CMD_PUSH_FRONT) begin
              ctl.op = ilst_pkg::OP_INSERT;
            end else begin
              ctl.op = ilst_pkg::OP_WRITE;
              ctl.at = ilst_pkg::idx_t'(occ_r);
            end
          end
        end
        ilst_pkg::CMD_POP_FRONT,
        ilst_pkg::CMD_POP_BACK: begin
          if (occ_r == '0) begin
            st_nxt = ilst_pkg::ST_EMPTY;
          end else begin
            occ_nxt = occ_r - OCC_W'(1);
            if (cmd == ilst_pkg::CMD_POP_FRONT) begin
              ctl.op = ilst_pkg::OP_DELETE;
            end
          end
        end
        ilst_pkg::CMD_INSERT: begin
          if (pos_c > occ_c) begin
            st_nxt = ilst_pkg::ST_RANGE;
          end else if (occ_r == OCC_W'(CAPACITY)) begin
            st_nxt = ilst_pkg::ST_FULL;
          end else begin
            occ_nxt = occ_r + OCC_W'(1);
            ctl.op  = ilst_pkg::OP_INSERT;
            ctl.at  = ilst_pkg::idx_t'(pos_c);
          end
        end
        ilst_pkg::CMD_REMOVE: begin
          if (pos_c >= occ_c) begin
            st_nxt = ilst_pkg::ST_RANGE;
          end else begin
            occ_nxt = occ_r - OCC_W'(1);
            ctl.op  = ilst_pkg::OP_DELETE;
            ctl.at  = ilst_pkg::idx_t'(pos_c);
          end
        end
        ilst_pkg::CMD_GET: begin
          if (pos_c >= occ_c) begin
            st_nxt = ilst_pkg::ST_RANGE;
          end else begin
            get_nxt = 1'b1;
            ctl.op  = ilst_pkg::OP_GET;
            ctl.at  = ilst_pkg::idx_t'(pos_c);
          end
        end
        ilst_pkg::CMD_FIND: begin
          find_nxt = 1'b1;
          ctl.op   = ilst_pkg::OP_FIND;
        end
        ilst_pkg::CMD_CLEAR: occ_nxt = '0;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = new_val;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end
    ilst_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_val    (new_val),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .hit        (hit[i])
    );
  end

  // Lowest set match flag isolated by one subtract; then independent OR reductions
  assign first_hit = hit & ~(hit - CAPACITY'(1));

  always_comb begin
    hit_idx  = '0;
    hit_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_idx  = hit_idx | (first_hit[i] ? OCC_W'(i) : '0);
      hit_data = hit_data | (hit[i] ? cell_data[i] : '0);
    end
  end

  assign rd_wide = 64'(hit_data);

  always_comb begin
    out_data_nxt                = out_data_r;
    out_valid_nxt               = out_valid_r && !out_chan.ready;
    busy_nxt                    = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (load) begin
      busy_nxt                    = 1'b0;
      out_valid_nxt               = 1'b1;
      out_data_nxt.status         = st_r;
      out_data_nxt.read_value     = get_r ? rd_wide[31:0] : '0;
      out_data_nxt.found_position = '0;
      out_data_nxt.entry_count    = 5'(occ_r);
      out_data_nxt.is_empty       = (occ_r == '0);
      if (find_r) begin
        if (|hit) begin
          out_data_nxt.status         = ilst_pkg::ST_OK;
          out_data_nxt.found_position = 4'(hit_idx);
        end else begin
          out_data_nxt.status = ilst_pkg::ST_NOTFOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      st_r        <= ilst_pkg::ST_OK;
      find_r      <= 1'b0;
      get_r       <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      find_r      <= find_nxt;
      get_r       <= get_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && !in_chan.ready)
    else $error("request accepted but result stage not busy");

  a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !busy_r && out_valid_r)
    else $error("result load did not free the request slot");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == ilst_pkg::CMD_CLEAR |=> occ_r == '0)
    else $error("clear left entries behind");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == ilst_pkg::CMD_PUSH_BACK && occ_r != OCC_W'(CAPACITY)
      |=> occ_r == $past(occ_r) + OCC_W'(1))
    else $error("push back did not grow the list");

  a_get_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && get_r |-> $onehot(hit))
    else $error("get selected other than one cell");

endmodule
`default_nettype wire
